/* rtl/egc_pkg.sv */
package egc_pkg;

  localparam logic [1:0] FUNC_HALL = 2'd0;
  localparam logic [1:0] FUNC_CAR  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam int MAX_REPORT = 4;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_IDLE = 2'd2
  } dir_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic add_stop;
    logic tick_step;
    logic cnt_inc;
  } egc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic cnt_rep;
  } egc_sts_t;

endpackage

/* rtl/egc_ctrl.sv */
module egc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  egc_pkg::egc_sts_t sts,
  output egc_pkg::egc_cmd_t cmd
);
  import egc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ADD  = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            FUNC_HALL: state_nxt = S_SCAN;
            FUNC_CAR:  state_nxt = S_ADD;
            FUNC_TICK: state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_ADD;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.add_stop = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TICK: begin
        if (!sts.cnt_rep || sts.out_free) begin
          cmd.tick_step = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/egc_datapath.sv */
module egc_datapath #(
  parameter int NUM_CARS   = 4,
  parameter int NUM_FLOORS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  egc_pkg::egc_cmd_t cmd,
  output egc_pkg::egc_sts_t sts,
  input  logic [1:0]        in_func,
  input  logic [3:0]        in_floor,
  input  logic [1:0]        in_hall_direction,
  input  logic [1:0]        in_car,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [1:0]        out_car_index,
  output logic [3:0]        out_car_floor,
  output logic [1:0]        out_car_direction,
  output logic              out_stopped,
  output logic              out_last
);
  import egc_pkg::*;

  localparam int CW   = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int PW   = $clog2(NUM_FLOORS);
  localparam int DW   = (PW > 4) ? PW : 4;
  localparam int NREP = (NUM_CARS < MAX_REPORT) ? NUM_CARS : MAX_REPORT;

  logic [PW-1:0]         pos_r  [NUM_CARS];
  dir_t                  head_r [NUM_CARS];
  logic [NUM_FLOORS-1:0] up_r   [NUM_CARS];
  logic [NUM_FLOORS-1:0] dn_r   [NUM_CARS];

  logic [1:0]    func_r;
  logic [3:0]    floor_r;
  logic [1:0]    dir_r;
  logic [1:0]    car_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] best_r;
  logic [DW-1:0] best_dist_r;
  logic          found_r;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [1:0]    out_index_r;
  logic [3:0]    out_floor_r;
  logic [1:0]    out_dir_r;
  logic          out_stopped_r;
  logic          out_last_r;

  logic [2:0]            car3;
  logic [CW-1:0]         car_idx;
  logic                  car_ok;
  logic [CW-1:0]         tgt;
  logic [2:0]            tgt3;
  logic [2:0]            cnt3;
  logic [CW-1:0]         idx;
  logic [PW-1:0]         p;
  dir_t                  h;
  logic                  up_any;
  logic                  dn_any;
  logic [DW-1:0]         pe;
  logic [DW-1:0]         fe;
  logic [DW-1:0]         gap;
  logic                  eligible;
  logic                  floor_ok;
  logic [PW-1:0]         fidx;
  dir_t                  h_new;
  logic [PW-1:0]         p_new;
  logic [DW-1:0]         p_new_ext;
  logic                  hit;
  logic [NUM_FLOORS-1:0] up_new;
  logic [NUM_FLOORS-1:0] dn_new;
  logic                  add_ok;
  logic                  out_load;

  assign car3    = 3'(car_r);
  assign car_idx = car3[CW-1:0];
  assign car_ok  = (4'(car_r) < 4'(NUM_CARS));
  assign tgt     = (func_r == FUNC_CAR) ? car_idx : best_r;
  assign tgt3    = 3'(best_r);
  assign cnt3    = 3'(cnt_r);
  assign idx     = cmd.add_stop ? tgt : cnt_r;

  assign p      = pos_r[idx];
  assign h      = head_r[idx];
  assign up_any = |up_r[idx];
  assign dn_any = |dn_r[idx];

  assign pe       = DW'(p);
  assign fe       = DW'(floor_r);
  assign gap      = (pe > fe) ? (pe - fe) : (fe - pe);
  assign eligible = (h == dir_r) || ((h == DIR_IDLE) && !up_any && !dn_any);
  assign floor_ok = (7'(floor_r) < 7'(NUM_FLOORS));
  assign fidx     = fe[PW-1:0];
  assign add_ok   = floor_ok && ((func_r == FUNC_HALL) || car_ok);

  always_comb begin
    h_new = h;
    case (h)
      DIR_UP: begin
        if (!up_any) begin
          h_new = dn_any ? DIR_DOWN : DIR_IDLE;
        end
      end
      DIR_DOWN: begin
        if (!dn_any) begin
          h_new = up_any ? DIR_UP : DIR_IDLE;
        end
      end
      default: begin
        if (up_any) begin
          h_new = DIR_UP;
        end else if (dn_any) begin
          h_new = DIR_DOWN;
        end
      end
    endcase
  end

  always_comb begin
    p_new  = p;
    hit    = 1'b0;
    up_new = up_r[idx];
    dn_new = dn_r[idx];
    if (cmd.add_stop) begin
      if (fidx > p) begin
        up_new[fidx] = 1'b1;
      end else if (fidx < p) begin
        dn_new[fidx] = 1'b1;
      end
    end else if ((h_new == DIR_UP) && (p != PW'(NUM_FLOORS - 1))) begin
      p_new = p + 1'b1;
      hit   = up_r[idx][p_new];
      up_new[p_new] = 1'b0;
    end else if ((h_new == DIR_DOWN) && (p != '0)) begin
      p_new = p - 1'b1;
      hit   = dn_r[idx][p_new];
      dn_new[p_new] = 1'b0;
    end
  end

  assign p_new_ext = DW'(p_new);

  assign sts.cnt_last = (cnt_r == CW'(NUM_CARS - 1));
  assign sts.cnt_rep  = (4'(cnt_r) < 4'(NREP));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_load = cmd.add_stop || (cmd.tick_step && sts.cnt_rep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CARS; i++) begin
        pos_r[i]  <= '0;
        head_r[i] <= DIR_IDLE;
        up_r[i]   <= '0;
        dn_r[i]   <= '0;
      end
    end else if (cmd.tick_step) begin
      pos_r[idx]  <= p_new;
      head_r[idx] <= h_new;
      up_r[idx]   <= up_new;
      dn_r[idx]   <= dn_new;
    end else if (cmd.add_stop && add_ok) begin
      up_r[idx] <= up_new;
      dn_r[idx] <= dn_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.scan_step && eligible && (!found_r || (gap < best_dist_r))) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      floor_r <= in_floor;
      dir_r   <= in_hall_direction;
      car_r   <= in_car;
      best_r  <= '0;
    end else if (cmd.scan_step && eligible && (!found_r || (gap < best_dist_r))) begin
      best_r      <= cnt_r;
      best_dist_r <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= func_r;
      if (cmd.tick_step) begin
        out_index_r   <= cnt3[1:0];
        out_floor_r   <= p_new_ext[3:0];
        out_dir_r     <= h_new;
        out_stopped_r <= hit;
        out_last_r    <= (cnt_r == CW'(NREP - 1));
      end else begin
        out_index_r   <= (func_r == FUNC_CAR) ? car_r : tgt3[1:0];
        out_floor_r   <= floor_r;
        out_dir_r     <= 2'd0;
        out_stopped_r <= 1'b0;
        out_last_r    <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_car_index     = out_index_r;
  assign out_car_floor     = out_floor_r;
  assign out_car_direction = out_dir_r;
  assign out_stopped       = out_stopped_r;
  assign out_last          = out_last_r;

  // The output register must never be overwritten while it holds an untaken transaction.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_CARS - 1))
    else $error("car counter out of range");

  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == FUNC_TICK) && out_last_r) |->
      (3'(out_index_r) == 3'(NREP - 1)))
    else $error("tick report ends on the wrong car");

  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.tick_step && (cmd.add_stop || cmd.scan_step || cmd.load)))
    else $error("conflicting datapath commands");

endmodule

/* rtl/elevator_group_controller.sv */
// Nearest-car dispatcher for a group of NUM_CARS cars over NUM_FLOORS floors. A hall request
// (in_func 0) scans the cars one per cycle and then delivers one transaction naming the
// chosen car; a car request (in_func 1) delivers one transaction, and a tick (in_func 2)
// steps one car per cycle, pausing while a reported car's result waits on the output
// register, and delivers one transaction for each of the first MAX_REPORT cars (all cars if
// fewer) with out_last on the final one. All cars share a single evaluation unit, and a
// stalled out_ready holds the block. in_func 3 is accepted and produces no transaction. The
// next item is taken once the previous one has finished its work, even while its last
// result still waits on the output register.
module elevator_group_controller #(
  parameter int NUM_CARS   = 4,
  parameter int NUM_FLOORS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [3:0] in_floor,
  input  logic [1:0] in_hall_direction,
  input  logic [1:0] in_car,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [1:0] out_car_index,
  output logic [3:0] out_car_floor,
  output logic [1:0] out_car_direction,
  output logic       out_stopped,
  output logic       out_last
);
  import egc_pkg::*;

  egc_cmd_t cmd;
  egc_sts_t sts;

  egc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd)
  );

  egc_datapath #(
    .NUM_CARS   (NUM_CARS),
    .NUM_FLOORS (NUM_FLOORS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_floor          (in_floor),
    .in_hall_direction (in_hall_direction),
    .in_car            (in_car),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_car_index     (out_car_index),
    .out_car_floor     (out_car_floor),
    .out_car_direction (out_car_direction),
    .out_stopped       (out_stopped),
    .out_last          (out_last)
  );

endmodule

/* dv/tb_elevator_group_controller.sv */
module tb_elevator_group_controller;
  import egc_pkg::*;

  localparam int NUM_CARS = 4;
  localparam int NUM_FLOORS = 16;
  localparam int LAST_REPORTED = (NUM_CARS < MAX_REPORT ? NUM_CARS : MAX_REPORT) - 1;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] HALL_DIR_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 136;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] car_index;
    logic [3:0] car_floor;
    logic [1:0] car_direction;
    logic       stopped;
    logic       last;
  } car_report_t;

  class dispatch_scoreboard;
    logic [3:0] position [NUM_CARS];
    dir_t heading [NUM_CARS];
    logic [NUM_FLOORS-1:0] up_stops [NUM_CARS];
    logic [NUM_FLOORS-1:0] down_stops [NUM_CARS];
    car_report_t pending_reports [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned stops_seen;

    function new();
      for (int c = 0; c < NUM_CARS; c++) begin
        position[c] = '0;
        heading[c] = DIR_IDLE;
        up_stops[c] = '0;
        down_stops[c] = '0;
      end
      mismatches = 0;
      checked = 0;
      stops_seen = 0;
    endfunction

    function string describe(car_report_t r);
      return $sformatf("kind=%0d car=%0d floor=%0d dir=%0d stopped=%0b last=%0b",
                       r.kind, r.car_index, r.car_floor, r.car_direction, r.stopped, r.last);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    function void add_stop(int c, logic [3:0] f);
      if (int'(f) >= NUM_FLOORS) return;
      if (f > position[c]) up_stops[c][f] = 1'b1;
      else if (f < position[c]) down_stops[c][f] = 1'b1;
    endfunction

    function void renew_heading(int c);
      logic any_up;
      logic any_down;
      any_up = |up_stops[c];
      any_down = |down_stops[c];
      case (heading[c])
        DIR_UP: begin
          if (!any_up) heading[c] = any_down ? DIR_DOWN : DIR_IDLE;
        end
        DIR_DOWN: begin
          if (!any_down) heading[c] = any_up ? DIR_UP : DIR_IDLE;
        end
        default: begin
          if (any_up) heading[c] = DIR_UP;
          else if (any_down) heading[c] = DIR_DOWN;
        end
      endcase
    endfunction

    function bit advance_car(int c);
      renew_heading(c);
      if (heading[c] == DIR_UP && int'(position[c]) + 1 < NUM_FLOORS) begin
        position[c] = position[c] + 4'd1;
        if (up_stops[c][position[c]]) begin
          up_stops[c][position[c]] = 1'b0;
          return 1'b1;
        end
      end else if (heading[c] == DIR_DOWN && position[c] != 4'd0) begin
        position[c] = position[c] - 4'd1;
        if (down_stops[c][position[c]]) begin
          down_stops[c][position[c]] = 1'b0;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int nearest_car(logic [3:0] f, logic [1:0] dir);
      int best;
      int best_dist;
      int gap;
      bit found;
      bit free;
      best = 0;
      best_dist = 0;
      found = 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        gap = (position[c] > f) ? int'(position[c]) - int'(f) : int'(f) - int'(position[c]);
        free = heading[c] == DIR_IDLE && up_stops[c] == '0 && down_stops[c] == '0;
        if ((heading[c] == dir || free) && (!found || gap < best_dist)) begin
          found = 1'b1;
          best_dist = gap;
          best = c;
        end
      end
      return best;
    endfunction

    function void note_request(logic [1:0] func, logic [3:0] f, logic [1:0] dir,
                               logic [1:0] car);
      car_report_t r;
      int target;
      r = '0;
      if (func == FUNC_HALL || func == FUNC_CAR) begin
        if (func == FUNC_HALL) begin
          target = nearest_car(f, dir);
          add_stop(target, f);
        end else begin
          target = int'(car);
          if (target < NUM_CARS) add_stop(target, f);
        end
        r.kind = func;
        r.car_index = 2'(target);
        r.car_floor = f;
        r.last = 1'b1;
        pending_reports.push_back(r);
      end else if (func == FUNC_TICK) begin
        for (int c = 0; c < NUM_CARS; c++) begin
          r.kind = FUNC_TICK;
          r.car_index = 2'(c);
          r.stopped = advance_car(c);
          r.car_floor = position[c];
          r.car_direction = heading[c];
          r.last = (c == LAST_REPORTED);
          if (c < MAX_REPORT) pending_reports.push_back(r);
        end
      end
    endfunction

    task check_report(car_report_t got);
      car_report_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("result with nothing expected: %s", describe(got)));
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("expected %s, got %s", describe(want), describe(got)));
      else if (got.stopped)
        stops_seen++;
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [3:0] in_floor;
  logic [1:0] in_hall_direction;
  logic [1:0] in_car;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [1:0] out_car_index;
  logic [3:0] out_car_floor;
  logic [1:0] out_car_direction;
  logic       out_stopped;
  logic       out_last;

  dispatch_scoreboard sb;
  bit calm;
  bit hold_request;
  int unsigned func_counts [4];

  elevator_group_controller #(
    .NUM_CARS(NUM_CARS),
    .NUM_FLOORS(NUM_FLOORS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_floor(in_floor),
    .in_hall_direction(in_hall_direction),
    .in_car(in_car),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_car_index(out_car_index),
    .out_car_floor(out_car_floor),
    .out_car_direction(out_car_direction),
    .out_stopped(out_stopped),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_func, in_floor, in_hall_direction, in_car);
        func_counts[in_func]++;
      end
      if (out_valid && out_ready)
        sb.check_report(car_report_t'{out_kind, out_car_index, out_car_floor,
                                      out_car_direction, out_stopped, out_last});
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timed out after %0d cycles without a transaction.", WATCHDOG_LIMIT);
    $display("elevator_group_controller test failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] func, input logic [3:0] floor_no,
                           input logic [1:0] dir, input logic [1:0] car);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_floor <= floor_no;
    in_hall_direction <= dir;
    in_car <= car;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(FUNC_TICK, 4'd0, DIR_UP, 2'd0);
  endtask

  initial begin : stimulus
    int sent;
    int pick;
    logic [1:0] func;
    sb = new();
    calm = 1'b0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_HALL;
    in_floor <= 4'd0;
    in_hall_direction <= DIR_UP;
    in_car <= 2'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Hall requests with all cars idle, then a car idle with stops, then the unused direction.
    send_ticks(1);
    send_item(FUNC_HALL, 4'd15, DIR_UP, 2'd0);
    send_item(FUNC_HALL, 4'd0, DIR_DOWN, 2'd3);
    send_item(FUNC_HALL, 4'd8, DIR_IDLE, 2'd0);
    send_item(FUNC_HALL, 4'd5, HALL_DIR_UNUSED, 2'd0);
    send_item(FUNC_CAR, 4'd3, DIR_UP, 2'd2);
    send_item(FUNC_CAR, 4'd0, DIR_UP, 2'd3);
    send_item(FUNC_CAR, 4'd15, DIR_DOWN, 2'd3);
    send_item(FUNC_UNUSED, 4'd9, DIR_DOWN, 2'd1);
    send_ticks(3);
    send_item(FUNC_CAR, 4'd0, DIR_UP, 2'd0);
    send_item(FUNC_HALL, 4'd2, DIR_UP, 2'd2);
    send_ticks(6);
    send_item(FUNC_HALL, 4'd10, DIR_DOWN, 2'd1);
    send_ticks(3);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 20) hold_request = 1'b1;
      calm = (sent >= 70 && sent < 120);
      pick = $urandom_range(0, 99);
      if (pick < 35) func = FUNC_HALL;
      else if (pick < 60) func = FUNC_CAR;
      else if (pick < 95) func = FUNC_TICK;
      else func = FUNC_UNUSED;
      send_item(func, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)));
      if (func != FUNC_UNUSED) sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Accepted %0d hall requests, %0d car requests, %0d ticks and %0d unused codes.",
             func_counts[FUNC_HALL], func_counts[FUNC_CAR], func_counts[FUNC_TICK],
             func_counts[FUNC_UNUSED]);
    $display("Checked %0d results, %0d of them with a car stopping; %0d mismatches.",
             sb.checked, sb.stops_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("elevator_group_controller test passed");
    end else begin
      $display("elevator_group_controller test failed");
    end
    $finish;
  end

endmodule
